// ===== hdl/cicgn_pkg.sv =====
// shared widths and pipeline depth constants for the circle contact gap/normal block
// no dependencies
package cicgn_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned DiffW   = 33;
    localparam int unsigned SqW     = 66;
    localparam int unsigned RootW   = 33;
    localparam int unsigned RemW    = 37;
    localparam int unsigned RadW    = 31;
    localparam int unsigned GapW    = 33;
    localparam int unsigned NormW   = 16;
    localparam int unsigned QuotW   = 15;
    localparam int unsigned NumW    = 48;
    localparam int unsigned FracN   = 14;
    localparam int unsigned CfgIdxW = 8;

    localparam int unsigned RootSteps = RootW;
    localparam int unsigned DivSteps  = QuotW;

    // edges from accepted start to the registered result
    localparam int unsigned Latency = 4 + RootSteps + 1 + 1 + DivSteps + 1;

    localparam logic [CfgIdxW-1:0] RegRadiusOne = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegRadiusTwo = CfgIdxW'(1);

    localparam logic [QuotW-1:0] NormMax = QuotW'(16384);

    typedef struct packed {
        logic             sx;
        logic             sy;
        logic [DiffW-1:0] ax;
        logic [DiffW-1:0] ay;
        logic             coin;
    } t_side;

endpackage

// ===== hdl/circle_in_circle_gap_normal.sv =====
// circle inside circle contact: gap and unit centre normal, fully pipelined
// one transfer accepted per cycle, o_busy stays low
// the square root (33 one-bit stages) and the two 15-stage dividers set the depth
// synchronous active-low reset clears the valid chain and sets the radii (1.0 each)
// results appear as a one-cycle strobe; the receiver cannot stall them
module circle_in_circle_gap_normal
    import cicgn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [CoordW-1:0]    i_first_x,
    input  logic signed [CoordW-1:0]    i_first_y,
    input  logic signed [CoordW-1:0]    i_second_x,
    input  logic signed [CoordW-1:0]    i_second_y,
    input  logic                        i_cfg_we,
    input  logic [CfgIdxW-1:0]          i_cfg_idx,
    input  logic [RadW-1:0]             i_cfg_data,
    output logic                        o_valid,
    output logic signed [GapW-1:0]      o_gap,
    output logic signed [NormW-1:0]     o_normal_x,
    output logic signed [NormW-1:0]     o_normal_y,
    output logic                        o_coincident
);

    logic [RadW-1:0] r_rad_one, r_rad_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_one <= RadW'(65536);
            r_rad_two <= RadW'(65536);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == RegRadiusOne) r_rad_one <= i_cfg_data;
            if (i_cfg_idx == RegRadiusTwo) r_rad_two <= i_cfg_data;
        end
    end

    assign o_busy = 1'b0;

    // stage 1: differences and magnitudes
    logic signed [DiffW-1:0] n_dx, n_dy;
    logic                    r1_v;
    t_side                   r1_sd;

    assign n_dx = DiffW'(i_second_x) - DiffW'(i_first_x);
    assign n_dy = DiffW'(i_second_y) - DiffW'(i_first_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_start;
    end

    always_ff @(posedge i_clk) begin
        r1_sd.sx   <= n_dx[DiffW-1];
        r1_sd.sy   <= n_dy[DiffW-1];
        r1_sd.ax   <= n_dx[DiffW-1] ? -n_dx : n_dx;
        r1_sd.ay   <= n_dy[DiffW-1] ? -n_dy : n_dy;
        r1_sd.coin <= 1'b0;
    end

    // stage 2: partial products, magnitude split as hi(16) : lo(17)
    logic        r2_v;
    t_side       r2_sd;
    logic [33:0] r2_xll, r2_yll;
    logic [32:0] r2_xlh, r2_ylh;
    logic [31:0] r2_xhh, r2_yhh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        r2_sd  <= r1_sd;
        r2_xll <= 34'(r1_sd.ax[16:0]) * 34'(r1_sd.ax[16:0]);
        r2_xlh <= 33'(r1_sd.ax[32:17]) * 33'(r1_sd.ax[16:0]);
        r2_xhh <= 32'(r1_sd.ax[32:17]) * 32'(r1_sd.ax[32:17]);
        r2_yll <= 34'(r1_sd.ay[16:0]) * 34'(r1_sd.ay[16:0]);
        r2_ylh <= 33'(r1_sd.ay[32:17]) * 33'(r1_sd.ay[16:0]);
        r2_yhh <= 32'(r1_sd.ay[32:17]) * 32'(r1_sd.ay[32:17]);
    end

    // stage 3: squares
    logic          r3_v;
    t_side         r3_sd;
    logic [SqW-1:0] r3_sqx, r3_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        r3_sd  <= r2_sd;
        r3_sqx <= (SqW'(r2_xhh) << 34) + (SqW'(r2_xlh) << 18) + SqW'(r2_xll);
        r3_sqy <= (SqW'(r2_yhh) << 34) + (SqW'(r2_ylh) << 18) + SqW'(r2_yll);
    end

    // stage 4 feeds the root chain: sum of squares
    logic           r_rt_v   [0:RootSteps];
    t_side          r_rt_sd  [0:RootSteps];
    logic [SqW-1:0] r_rt_s   [0:RootSteps];
    logic [RemW-3:0] r_rt_rem [0:RootSteps];
    logic [RootW-1:0] r_rt_q  [0:RootSteps];
    logic [SqW-1:0] n_sum;

    assign n_sum = r3_sqx + r3_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rt_v[0] <= 1'b0;
        else          r_rt_v[0] <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        r_rt_sd[0].sx   <= r3_sd.sx;
        r_rt_sd[0].sy   <= r3_sd.sy;
        r_rt_sd[0].ax   <= r3_sd.ax;
        r_rt_sd[0].ay   <= r3_sd.ay;
        r_rt_sd[0].coin <= (n_sum == '0);
        r_rt_s[0]       <= n_sum;
        r_rt_rem[0]     <= '0;
        r_rt_q[0]       <= '0;
    end

    // one root bit per stage, restoring form
    for (genvar k = 0; k < RootSteps; k++) begin : g_root
        logic [RemW-1:0] n_cur, n_trial;
        logic            n_take;

        assign n_cur   = {r_rt_rem[k], r_rt_s[k][SqW-1 -: 2]};
        assign n_trial = {2'b00, r_rt_q[k], 2'b01};
        assign n_take  = (n_cur >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_rt_v[k+1] <= 1'b0;
            else          r_rt_v[k+1] <= r_rt_v[k];
        end

        always_ff @(posedge i_clk) begin
            r_rt_sd[k+1]  <= r_rt_sd[k];
            r_rt_s[k+1]   <= r_rt_s[k] << 2;
            r_rt_rem[k+1] <= n_take ? (RemW-2)'(n_cur - n_trial) : n_cur[RemW-3:0];
            r_rt_q[k+1]   <= {r_rt_q[k][RootW-2:0], n_take};
        end
    end

    // round to nearest: remainder above root means the upper code is closer
    logic             r_rd_v;
    t_side            r_rd_sd;
    logic [RootW-1:0] r_rd_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_v <= 1'b0;
        else          r_rd_v <= r_rt_v[RootSteps];
    end

    always_ff @(posedge i_clk) begin
        r_rd_sd   <= r_rt_sd[RootSteps];
        r_rd_dist <= r_rt_q[RootSteps]
                   + RootW'(r_rt_rem[RootSteps] > (RemW-2)'(r_rt_q[RootSteps]));
    end

    // gap and divider set-up
    logic [RadW-1:0]        n_rdiff;
    logic signed [GapW+1:0] n_gapw;
    logic signed [GapW-1:0] n_gap;
    logic [RootW-1:0]       n_den;

    assign n_rdiff = (r_rad_one >= r_rad_two) ? (r_rad_one - r_rad_two)
                                              : (r_rad_two - r_rad_one);
    assign n_gapw  = $signed((GapW+2)'(n_rdiff)) - $signed((GapW+2)'(r_rd_dist));
    assign n_gap   = (n_gapw < -$signed((GapW+2)'(64'h1_0000_0000)))
                   ? {1'b1, {(GapW-1){1'b0}}} : n_gapw[GapW-1:0];
    assign n_den   = r_rd_sd.coin ? RootW'(1) : r_rd_dist;

    logic             r_dv_v    [0:DivSteps];
    t_side            r_dv_sd   [0:DivSteps];
    logic [GapW-1:0]  r_dv_gap  [0:DivSteps];
    logic [RootW-1:0] r_dv_den  [0:DivSteps];
    logic [NumW-1:0]  r_dv_rx   [0:DivSteps];
    logic [NumW-1:0]  r_dv_ry   [0:DivSteps];
    logic [QuotW-1:0] r_dv_qx   [0:DivSteps];
    logic [QuotW-1:0] r_dv_qy   [0:DivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_v[0] <= 1'b0;
        else          r_dv_v[0] <= r_rd_v;
    end

    always_ff @(posedge i_clk) begin
        r_dv_sd[0]  <= r_rd_sd;
        r_dv_gap[0] <= n_gap;
        r_dv_den[0] <= n_den;
        r_dv_rx[0]  <= (NumW'(r_rd_sd.ax) << FracN) + NumW'(n_den >> 1);
        r_dv_ry[0]  <= (NumW'(r_rd_sd.ay) << FracN) + NumW'(n_den >> 1);
        r_dv_qx[0]  <= '0;
        r_dv_qy[0]  <= '0;
    end

    // long division, one quotient bit per stage for both lanes
    for (genvar j = 0; j < DivSteps; j++) begin : g_div
        localparam int unsigned Sh = DivSteps - 1 - j;
        logic [NumW-1:0] n_sub;
        logic            n_tx, n_ty;

        assign n_sub = NumW'(r_dv_den[j]) << Sh;
        assign n_tx  = (r_dv_rx[j] >= n_sub);
        assign n_ty  = (r_dv_ry[j] >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[j+1] <= 1'b0;
            else          r_dv_v[j+1] <= r_dv_v[j];
        end

        always_ff @(posedge i_clk) begin
            r_dv_sd[j+1]  <= r_dv_sd[j];
            r_dv_gap[j+1] <= r_dv_gap[j];
            r_dv_den[j+1] <= r_dv_den[j];
            r_dv_rx[j+1]  <= n_tx ? (r_dv_rx[j] - n_sub) : r_dv_rx[j];
            r_dv_ry[j+1]  <= n_ty ? (r_dv_ry[j] - n_sub) : r_dv_ry[j];
            r_dv_qx[j+1]  <= {r_dv_qx[j][QuotW-2:0], n_tx};
            r_dv_qy[j+1]  <= {r_dv_qy[j][QuotW-2:0], n_ty};
        end
    end

    // output register: clamp, sign, zero on coincident centres
    logic [QuotW-1:0] n_mx, n_my;
    t_side            n_osd;

    assign n_osd = r_dv_sd[DivSteps];
    assign n_mx  = (r_dv_qx[DivSteps] > NormMax) ? NormMax : r_dv_qx[DivSteps];
    assign n_my  = (r_dv_qy[DivSteps] > NormMax) ? NormMax : r_dv_qy[DivSteps];

    logic                     r_o_v;
    logic [GapW-1:0]          r_o_gap;
    logic [NormW-1:0]         r_o_nx, r_o_ny;
    logic                     r_o_coin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else          r_o_v <= r_dv_v[DivSteps];
    end

    always_ff @(posedge i_clk) begin
        r_o_gap  <= r_dv_gap[DivSteps];
        r_o_coin <= n_osd.coin;
        if (n_osd.coin) begin
            r_o_nx <= '0;
            r_o_ny <= '0;
        end else begin
            r_o_nx <= n_osd.sx ? -NormW'(n_mx) : NormW'(n_mx);
            r_o_ny <= n_osd.sy ? -NormW'(n_my) : NormW'(n_my);
        end
    end

    assign o_valid      = r_o_v;
    assign o_gap        = r_o_gap;
    assign o_normal_x   = r_o_nx;
    assign o_normal_y   = r_o_ny;
    assign o_coincident = r_o_coin;

endmodule

// ===== hdl/cicgn_checker.sv =====
// port-level checks for the circle contact gap/normal block
// depends on cicgn_pkg; bound to circle_in_circle_gap_normal below
module cicgn_checker
    import cicgn_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_busy,
    input logic                     o_valid,
    input logic signed [GapW-1:0]   o_gap,
    input logic signed [NormW-1:0]  o_normal_x,
    input logic signed [NormW-1:0]  o_normal_y,
    input logic                     o_coincident
);

    // no result straight after a reset cycle
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result transfer right after reset");

    a_coin_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coincident) |-> (o_normal_x == '0 && o_normal_y == '0))
        else $error("coincident centres with non-zero direction");

    // with zero distance the gap is a plain radius difference
    a_coin_gap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coincident) |-> !o_gap[GapW-1])
        else $error("coincident centres with negative gap");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
                  && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384))
        else $error("normal component out of unit range");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("pipeline reported busy");

endmodule

bind circle_in_circle_gap_normal cicgn_checker u_cicgn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_gap        (o_gap),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_coincident (o_coincident)
);
